// ===== hdl/ecd_pkg.sv =====
// Shared types and constants for the EBCDIC codepage detector.
package ecd_pkg;

    // Counter and percent widths
    localparam int CNT_W  = 25;
    localparam int PCT_W  = 7;
    localparam int PROD_W = CNT_W + PCT_W;
    localparam int IDX_W  = 2;

    // Stream payload widths (bytes, zero-padded)
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    // Byte limit of one file; counters stop at the smaller of this and their full range
    localparam longint unsigned ECD_MAX_BYTES = 64'd16777216;
    localparam longint unsigned CNT_MAX       = (64'd1 << CNT_W) - 64'd1;
    localparam logic [CNT_W-1:0] CNT_LIMIT    =
        CNT_W'((ECD_MAX_BYTES > CNT_MAX) ? CNT_MAX : ECD_MAX_BYTES);

    // Percent scale
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RAW_SKIP    = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_DECODED = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_MARGIN  = 2'd2;

    // Register reset values
    localparam logic [PCT_W-1:0] RST_RAW_SKIP    = 7'd95;
    localparam logic [PCT_W-1:0] RST_MIN_DECODED = 7'd90;
    localparam logic [PCT_W-1:0] RST_MIN_MARGIN  = 7'd10;

    // Decision codes
    typedef enum logic [1:0] {
        DEC_KEEP  = 2'd0,
        DEC_CP037 = 2'd1,
        DEC_CP500 = 2'd2
    } t_decision;

    // Per-byte classification
    typedef struct packed {
        logic raw;
        logic cp037;
        logic cp500;
    } t_class;

    // Running counts of one file
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] raw;
        logic [CNT_W-1:0] cp037;
        logic [CNT_W-1:0] cp500;
        logic             ovf;
    } t_counts;

endpackage

// ===== hdl/ebcdic_codepage_detector.sv =====
// Top level of the EBCDIC codepage detector.
//
// Slave stream: one file byte per beat in i_s_tdata, i_s_tlast on the
// final byte of the file. Master stream: one result beat per file, sent
// after the final byte. Configuration: i_cfg_we with i_cfg_idx selects
// 0 raw skip percent, 1 least decoded percent, 2 margin percent; write
// only while no file is in progress and no result is pending.
// Throughput is one byte per clock while o_s_tready is high; each byte
// passes the input register and the counter stage, so bytes stream
// without gaps. The final byte of a file passes the input register,
// counter snapshot, share products and result register before the
// result beat shows o_m_tvalid. A new file may start on the next beat.
// Reset clears the counters and the pipeline and loads the thresholds
// 95, 90 and 10. When the receiver holds i_m_tready low the result
// register holds its beat; later final bytes back up into the snapshot
// and product stages, and o_s_tready drops only once a final byte finds
// no free slot. Ordinary bytes keep flowing until then.
module ebcdic_codepage_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ecd_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] byte_in
    input  logic                            i_s_tlast,   // last_byte
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] decision, [26:2] byte_total, [51:27] raw_good_count,
    // [76:52] best_good_count, [77] length_overflow, [79:78] zero
    output logic [ecd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [ecd_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [ecd_pkg::PCT_W-1:0]       i_cfg_data
);
    import ecd_pkg::*;

    logic    w_snap_valid;
    logic    w_snap_ready;
    t_counts w_snap;

    ecd_count u_count (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap),
        .i_snap_ready (w_snap_ready)
    );

    ecd_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_ready (w_snap_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

// ===== hdl/ecd_class.sv =====
// Byte classifier: good-character test raw, through cp037 and through cp500.
module ecd_class (
    input  logic [7:0]    i_byte,
    output ecd_pkg::t_class o_class
);
    import ecd_pkg::*;

    localparam logic [7:0] CP037_MAP [256] = '{
        8'h00,8'h01,8'h02,8'h03,8'h9c,8'h09,8'h86,8'h7f,8'h97,8'h8d,8'h8e,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h9d,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8f,8'h1c,8'h1d,8'h1e,8'h1f,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h0a,8'h17,8'h1b,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h05,8'h06,8'h07,
        8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9a,8'h9b,8'h14,8'h15,8'h9e,8'h1a,
        8'h20,8'ha0,8'he2,8'he4,8'he0,8'he1,8'he3,8'he5,8'he7,8'hf1,8'ha2,8'h2e,8'h3c,8'h28,8'h2b,8'h7c,
        8'h26,8'he9,8'hea,8'heb,8'he8,8'hed,8'hee,8'hef,8'hec,8'hdf,8'h21,8'h24,8'h2a,8'h29,8'h3b,8'hac,
        8'h2d,8'h2f,8'hc2,8'hc4,8'hc0,8'hc1,8'hc3,8'hc5,8'hc7,8'hd1,8'ha6,8'h2c,8'h25,8'h5f,8'h3e,8'h3f,
        8'hf8,8'hc9,8'hca,8'hcb,8'hc8,8'hcd,8'hce,8'hcf,8'hcc,8'h60,8'h3a,8'h23,8'h40,8'h27,8'h3d,8'h22,
        8'hd8,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hab,8'hbb,8'hf0,8'hfd,8'hfe,8'hb1,
        8'hb0,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'haa,8'hba,8'he6,8'hb8,8'hc6,8'ha4,
        8'hb5,8'h7e,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'ha1,8'hbf,8'hd0,8'hdd,8'hde,8'hae,
        8'h5e,8'ha3,8'ha5,8'hb7,8'ha9,8'ha7,8'hb6,8'hbc,8'hbd,8'hbe,8'h5b,8'h5d,8'haf,8'ha8,8'hb4,8'hd7,
        8'h7b,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'had,8'hf4,8'hf6,8'hf2,8'hf3,8'hf5,
        8'h7d,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'hb9,8'hfb,8'hfc,8'hf9,8'hfa,8'hff,
        8'h5c,8'hf7,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'hb2,8'hd4,8'hd6,8'hd2,8'hd3,8'hd5,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hb3,8'hdb,8'hdc,8'hd9,8'hda,8'h9f
    };

    localparam logic [7:0] CP500_MAP [256] = '{
        8'h00,8'h01,8'h02,8'h03,8'h9c,8'h09,8'h86,8'h7f,8'h97,8'h8d,8'h8e,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h9d,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8f,8'h1c,8'h1d,8'h1e,8'h1f,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h0a,8'h17,8'h1b,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h05,8'h06,8'h07,
        8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9a,8'h9b,8'h14,8'h15,8'h9e,8'h1a,
        8'h20,8'ha0,8'he2,8'he4,8'he0,8'he1,8'he3,8'he5,8'he7,8'hf1,8'h5b,8'h2e,8'h3c,8'h28,8'h2b,8'h21,
        8'h26,8'he9,8'hea,8'heb,8'he8,8'hed,8'hee,8'hef,8'hec,8'hdf,8'h5d,8'h24,8'h2a,8'h29,8'h3b,8'h5e,
        8'h2d,8'h2f,8'hc2,8'hc4,8'hc0,8'hc1,8'hc3,8'hc5,8'hc7,8'hd1,8'ha6,8'h2c,8'h25,8'h5f,8'h3e,8'h3f,
        8'hf8,8'hc9,8'hca,8'hcb,8'hc8,8'hcd,8'hce,8'hcf,8'hcc,8'h60,8'h3a,8'h23,8'h40,8'h27,8'h3d,8'h22,
        8'hd8,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hab,8'hbb,8'hf0,8'hfd,8'hfe,8'hb1,
        8'hb0,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'haa,8'hba,8'he6,8'hb8,8'hc6,8'ha4,
        8'hb5,8'h7e,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'ha1,8'hbf,8'hd0,8'hdd,8'hde,8'hae,
        8'ha2,8'ha3,8'ha5,8'hb7,8'ha9,8'ha7,8'hb6,8'hbc,8'hbd,8'hbe,8'hac,8'h7c,8'haf,8'ha8,8'hb4,8'hd7,
        8'h7b,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'had,8'hf4,8'hf6,8'hf2,8'hf3,8'hf5,
        8'h7d,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'hb9,8'hfb,8'hfc,8'hf9,8'hfa,8'hff,
        8'h5c,8'hf7,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'hb2,8'hd4,8'hd6,8'hd2,8'hd3,8'hd5,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hb3,8'hdb,8'hdc,8'hd9,8'hda,8'h9f
    };

    // Tab, LF, CR or printable ASCII
    function automatic logic is_good(input logic [7:0] c);
        return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               ((c >= 8'h20) && (c < 8'h7F));
    endfunction

    // Three lookups in parallel
    always_comb begin
        o_class.raw   = is_good(i_byte);
        o_class.cp037 = is_good(CP037_MAP[i_byte]);
        o_class.cp500 = is_good(CP500_MAP[i_byte]);
    end

endmodule

// ===== hdl/ecd_count.sv =====
// Input register, saturating good-byte counters and end-of-file snapshot.
module ecd_count (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_snap_valid,
    output ecd_pkg::t_counts o_snap,
    input  logic            i_snap_ready
);
    import ecd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_counts    r_cnt;
    t_counts    n_cnt;
    logic       r_snap_valid;
    t_counts    r_snap;
    t_class     w_class;
    logic       w_in_fire;

    ecd_class u_class (
        .i_byte  (r_in_byte),
        .o_class (w_class)
    );

    // A last beat leaves the input register only when the snapshot slot frees up
    assign w_in_fire  = r_in_valid && (!r_in_last || !r_snap_valid || i_snap_ready);
    assign o_s_tready = !r_in_valid || w_in_fire;

    // Counter update; at the limit nothing counts and overflow is flagged
    always_comb begin
        n_cnt = r_cnt;
        if (r_cnt.total < CNT_LIMIT) begin
            n_cnt.total = r_cnt.total + CNT_W'(1);
            n_cnt.raw   = r_cnt.raw   + CNT_W'(w_class.raw);
            n_cnt.cp037 = r_cnt.cp037 + CNT_W'(w_class.cp037);
            n_cnt.cp500 = r_cnt.cp500 + CNT_W'(w_class.cp500);
        end else begin
            n_cnt.ovf = 1'b1;
        end
    end

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_cnt        <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_in_fire) begin
                r_cnt <= r_in_last ? '0 : n_cnt;
            end
            if (w_in_fire && r_in_last) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
        if (w_in_fire && r_in_last) begin
            r_snap <= n_cnt;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

// ===== hdl/ecd_decide.sv =====
// Threshold registers, share products and the keep/decode decision.
module ecd_decide (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecd_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [ecd_pkg::PCT_W-1:0]       i_cfg_data,
    input  logic                            i_snap_valid,
    input  ecd_pkg::t_counts                i_snap,
    output logic                            o_snap_ready,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ecd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import ecd_pkg::*;

    logic [PCT_W-1:0]       r_skip_pct;
    logic [PCT_W-1:0]       r_dec_pct;
    logic [PCT_W-1:0]       r_mar_pct;

    logic                   r_prod_valid;
    logic [PROD_W-1:0]      r_r100;
    logic [PROD_W-1:0]      r_b100;
    logic [PROD_W-1:0]      r_skip_t;
    logic [PROD_W-1:0]      r_dec_t;
    logic [PROD_W-1:0]      r_mar_t;
    t_decision              r_pick;
    logic [CNT_W-1:0]       r_total;
    logic [CNT_W-1:0]       r_raw;
    logic [CNT_W-1:0]       r_best;
    logic                   r_ovf;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   w_out_free;
    logic                   w_pick500;
    logic [CNT_W-1:0]       w_best;
    logic [PROD_W:0]        w_raw_plus_mar;
    t_decision              n_decision;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_pct <= RST_RAW_SKIP;
            r_dec_pct  <= RST_MIN_DECODED;
            r_mar_pct  <= RST_MIN_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RAW_SKIP:    r_skip_pct <= i_cfg_data;
                REG_MIN_DECODED: r_dec_pct  <= i_cfg_data;
                REG_MIN_MARGIN:  r_mar_pct  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall chain: output register, then product stage
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign o_snap_ready = !r_prod_valid || w_out_free;

    // Better codepage, cp037 on a tie
    assign w_pick500 = i_snap.cp500 > i_snap.cp037;
    assign w_best    = w_pick500 ? i_snap.cp500 : i_snap.cp037;

    // Decision from the registered products
    assign w_raw_plus_mar = {1'b0, r_r100} + {1'b0, r_mar_t};
    always_comb begin
        n_decision = DEC_KEEP;
        if ((r_r100 < r_skip_t) && (r_b100 >= r_dec_t) &&
            ({1'b0, r_b100} >= w_raw_plus_mar)) begin
            n_decision = r_pick;
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_prod_valid <= i_snap_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_prod_valid;
            end
        end
    end

    // Product stage and result register payload
    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_r100   <= PROD_W'(i_snap.raw) * PROD_W'(PCT_FULL);
            r_b100   <= PROD_W'(w_best) * PROD_W'(PCT_FULL);
            r_skip_t <= PROD_W'(r_skip_pct) * PROD_W'(i_snap.total);
            r_dec_t  <= PROD_W'(r_dec_pct) * PROD_W'(i_snap.total);
            r_mar_t  <= PROD_W'(r_mar_pct) * PROD_W'(i_snap.total);
            r_pick   <= w_pick500 ? DEC_CP500 : DEC_CP037;
            r_total  <= i_snap.total;
            r_raw    <= i_snap.raw;
            r_best   <= w_best;
            r_ovf    <= i_snap.ovf;
        end
        if (w_out_free && r_prod_valid) begin
            r_out_data <= {2'b00, r_ovf, r_best, r_raw, r_total, n_decision};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/ecd_check.sv =====
// Port-level checks for the EBCDIC codepage detector, bound to the top level.
module ecd_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ecd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import ecd_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // Decision is a known code and every file has at least one byte
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3) && (o_m_tdata[26:2] != '0))
        else $error("bad decision code or empty total");

    // Good counts never exceed the total
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[51:27] <= o_m_tdata[26:2]) &&
                       (o_m_tdata[76:52] <= o_m_tdata[26:2]))
        else $error("good count above total");

    // A chosen codepage never scores below the raw bytes
    a_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != DEC_KEEP) |->
            (o_m_tdata[76:52] >= o_m_tdata[51:27]))
        else $error("decode chosen without gain over raw");

    // Reset empties the result register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind ebcdic_codepage_detector ecd_check u_ecd_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/ebcdic_codepage_detector_test.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the EBCDIC codepage detector.
module ebcdic_codepage_detector_test;
    import ecd_pkg::*;

    localparam longint unsigned FILE_BYTE_CAP = 64'd16777216;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SINK_LONG_HOLD  = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_BYTES    = 1280;
    localparam int N_PHASES        = 10;
    localparam int N_PRESETS       = 7;
    localparam int PRESSURE_PHASE  = 4;
    localparam int BURST_FILES     = 16;

    // Result beat, field by field
    typedef struct packed {
        t_decision        decision;
        logic [CNT_W-1:0] byte_total;
        logic [CNT_W-1:0] raw_good;
        logic [CNT_W-1:0] best_good;
        logic             length_ovf;
    } t_verdict;

    // One directed beat; want is used only where typed is set
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_verdict   want;
    } t_script_row;

    typedef enum int {
        TXT_ASCII,
        TXT_EBCDIC,
        TXT_CP500_HEAVY,
        TXT_CP037_HEAVY,
        TXT_NOISE
    } t_file_kind;

    // EBCDIC cp037 to Latin-1
    localparam logic [7:0] CP037_TO_LATIN1 [0:255] = '{
        8'h00,8'h01,8'h02,8'h03,8'h9c,8'h09,8'h86,8'h7f,8'h97,8'h8d,8'h8e,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h9d,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8f,8'h1c,8'h1d,8'h1e,8'h1f,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h0a,8'h17,8'h1b,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h05,8'h06,8'h07,
        8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9a,8'h9b,8'h14,8'h15,8'h9e,8'h1a,
        8'h20,8'ha0,8'he2,8'he4,8'he0,8'he1,8'he3,8'he5,8'he7,8'hf1,8'ha2,8'h2e,8'h3c,8'h28,8'h2b,8'h7c,
        8'h26,8'he9,8'hea,8'heb,8'he8,8'hed,8'hee,8'hef,8'hec,8'hdf,8'h21,8'h24,8'h2a,8'h29,8'h3b,8'hac,
        8'h2d,8'h2f,8'hc2,8'hc4,8'hc0,8'hc1,8'hc3,8'hc5,8'hc7,8'hd1,8'ha6,8'h2c,8'h25,8'h5f,8'h3e,8'h3f,
        8'hf8,8'hc9,8'hca,8'hcb,8'hc8,8'hcd,8'hce,8'hcf,8'hcc,8'h60,8'h3a,8'h23,8'h40,8'h27,8'h3d,8'h22,
        8'hd8,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hab,8'hbb,8'hf0,8'hfd,8'hfe,8'hb1,
        8'hb0,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'haa,8'hba,8'he6,8'hb8,8'hc6,8'ha4,
        8'hb5,8'h7e,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'ha1,8'hbf,8'hd0,8'hdd,8'hde,8'hae,
        8'h5e,8'ha3,8'ha5,8'hb7,8'ha9,8'ha7,8'hb6,8'hbc,8'hbd,8'hbe,8'h5b,8'h5d,8'haf,8'ha8,8'hb4,8'hd7,
        8'h7b,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'had,8'hf4,8'hf6,8'hf2,8'hf3,8'hf5,
        8'h7d,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'hb9,8'hfb,8'hfc,8'hf9,8'hfa,8'hff,
        8'h5c,8'hf7,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'hb2,8'hd4,8'hd6,8'hd2,8'hd3,8'hd5,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hb3,8'hdb,8'hdc,8'hd9,8'hda,8'h9f
    };

    // Directed beats under the reset thresholds 95/90/10
    localparam int SCRIPT_LEN = 20;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // one-byte files: both byte extremes, raw letter, EBCDIC letter, raw skip
        '{8'h00, 1'b1, 1'b1, '{DEC_KEEP,  25'd1, 25'd0, 25'd0, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{DEC_KEEP,  25'd1, 25'd0, 25'd0, 1'b0}},
        '{8'h41, 1'b1, 1'b1, '{DEC_KEEP,  25'd1, 25'd1, 25'd0, 1'b0}},
        '{8'hC1, 1'b1, 1'b1, '{DEC_CP037, 25'd1, 25'd0, 25'd1, 1'b0}},
        '{8'h4A, 1'b1, 1'b1, '{DEC_KEEP,  25'd1, 25'd1, 25'd1, 1'b0}},
        // cp500 wins on its own caret code
        '{8'hC1, 1'b0, 1'b0, '0},
        '{8'hC1, 1'b0, 1'b0, '0},
        '{8'h5F, 1'b1, 1'b1, '{DEC_CP500, 25'd3, 25'd1, 25'd3, 1'b0}},
        // EBCDIC tab, LF and CR
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h25, 1'b0, 1'b0, '0},
        '{8'h0D, 1'b1, 1'b1, '{DEC_CP037, 25'd3, 25'd2, 25'd3, 1'b0}},
        // raw tab/LF and the edges of the printable range
        '{8'h09, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h1F, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h7E, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{DEC_KEEP,  25'd6, 25'd4, 25'd2, 1'b0}},
        // codepage tie, left to the predictor
        '{8'hB0, 1'b0, 1'b0, '0},
        '{8'h4A, 1'b0, 1'b0, '0},
        '{8'h81, 1'b1, 1'b0, '0}
    };

    // Threshold presets: off, full, above range, lopsided, then reset values
    localparam logic [PCT_W-1:0] PRESET_SKIP    [N_PRESETS] =
        '{7'd0, 7'd100, 7'd127, 7'd100, 7'd127, 7'd127, 7'd95};
    localparam logic [PCT_W-1:0] PRESET_DECODED [N_PRESETS] =
        '{7'd0, 7'd100, 7'd127, 7'd0, 7'd100, 7'd0, 7'd90};
    localparam logic [PCT_W-1:0] PRESET_MARGIN  [N_PRESETS] =
        '{7'd0, 7'd100, 7'd127, 7'd0, 7'd0, 7'd100, 7'd10};
    localparam int NOISE_LEVELS [5] = '{0, 2, 10, 30, 100};
    localparam logic [7:0] ASCII_SPACES [3] = '{8'h09, 8'h0A, 8'h0D};
    localparam logic [IDX_W-1:0] REG_ORDER [3] = '{REG_RAW_SKIP, REG_MIN_DECODED, REG_MIN_MARGIN};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_we;
    logic [IDX_W-1:0]       i_cfg_idx;
    logic [PCT_W-1:0]       i_cfg_data;

    // Predictor copy of thresholds and running counts
    logic [PCT_W-1:0] skip_pct, decoded_pct, margin_pct;
    logic [CNT_W-1:0] cnt_total, cnt_raw, cnt_cp037, cnt_cp500;
    logic             cnt_ovf;

    t_verdict pending_verdicts [$];
    int fail_count   = 0;
    int bytes_sent   = 0;
    int files_done   = 0;
    int quiet_cycles = 0;
    int decisions_seen [3] = '{0, 0, 0};
    bit sink_hold_req = 1'b0;
    bit sink_no_stall = 1'b0;

    ebcdic_codepage_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit is_printable(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0A || c == 8'h0D || (c >= 8'h20 && c < 8'h7F);
    endfunction

    // cp500 differs from cp037 only at seven code points
    function automatic logic [7:0] cp500_latin1(input logic [7:0] b);
        case (b)
            8'h4A: return 8'h5B;
            8'h4F: return 8'h21;
            8'h5A: return 8'h5D;
            8'h5F: return 8'h5E;
            8'hB0: return 8'hA2;
            8'hBA: return 8'hAC;
            8'hBB: return 8'h7C;
            default: return CP037_TO_LATIN1[b];
        endcase
    endfunction

    // Count one byte; on the last byte of a file work out the verdict
    task automatic tally_byte(input logic [7:0] b, input logic last,
                              output bit done, output t_verdict v);
        longint unsigned t, r100, b100;
        logic [CNT_W-1:0] best;
        t_decision pick;
        done = 1'b0;
        v = '0;
        if (cnt_total < FILE_BYTE_CAP) begin
            cnt_total++;
            if (is_printable(b)) cnt_raw++;
            if (is_printable(CP037_TO_LATIN1[b])) cnt_cp037++;
            if (is_printable(cp500_latin1(b))) cnt_cp500++;
        end else begin
            cnt_ovf = 1'b1;
        end
        if (last) begin
            best = cnt_cp037;
            pick = DEC_CP037;
            if (cnt_cp500 > cnt_cp037) begin
                best = cnt_cp500;
                pick = DEC_CP500;
            end
            t    = cnt_total;
            r100 = 64'd100 * cnt_raw;
            b100 = 64'd100 * best;
            v.decision = DEC_KEEP;
            if (r100 < skip_pct * t && b100 >= decoded_pct * t &&
                b100 >= r100 + margin_pct * t)
                v.decision = pick;
            v.byte_total = cnt_total;
            v.raw_good   = cnt_raw;
            v.best_good  = best;
            v.length_ovf = cnt_ovf;
            cnt_total = '0;
            cnt_raw   = '0;
            cnt_cp037 = '0;
            cnt_cp500 = '0;
            cnt_ovf   = 1'b0;
            done      = 1'b1;
        end
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte(input t_file_kind kind);
        logic [7:0] b;
        case (kind)
            TXT_ASCII: begin
                if ($urandom_range(0, 7) == 0) b = ASCII_SPACES[$urandom_range(0, 2)];
                else b = 8'($urandom_range(8'h20, 8'h7E));
            end
            TXT_EBCDIC: begin
                do b = 8'($urandom); while (!is_printable(CP037_TO_LATIN1[b]));
            end
            TXT_CP500_HEAVY: begin
                if ($urandom_range(0, 3) == 0) b = ($urandom_range(0, 1) != 0) ? 8'h4A : 8'h5F;
                else do b = 8'($urandom); while (!is_printable(cp500_latin1(b)));
            end
            TXT_CP037_HEAVY: begin
                if ($urandom_range(0, 3) == 0) b = ($urandom_range(0, 1) != 0) ? 8'hB0 : 8'hBA;
                else do b = 8'($urandom); while (!is_printable(CP037_TO_LATIN1[b]));
            end
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // Offer one beat, wait for the handshake, then update the predictor
    task automatic feed_byte(input logic [7:0] b, input logic last, input int gap,
                             input logic typed, input t_verdict typed_want);
        t_verdict v;
        bit done;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
        tally_byte(b, last, done, v);
        if (typed) v = typed_want;
        if (done) pending_verdicts = {pending_verdicts, v};
    endtask

    task automatic send_file(input t_file_kind kind, input int len, input int noise_pct,
                             input bit no_gaps);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < noise_pct) b = 8'($urandom);
            else b = pick_byte(kind);
            feed_byte(b, k == len - 1, no_gaps ? 0 : pick_gap(), 1'b0, '0);
        end
    endtask

    // Hold the sender until every verdict is back and the pipeline is empty
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three thresholds on consecutive edges
    task automatic set_thresholds(input logic [PCT_W-1:0] s, input logic [PCT_W-1:0] d,
                                  input logic [PCT_W-1:0] m);
        logic [PCT_W-1:0] vals [3];
        vals = '{s, d, m};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_ORDER[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        skip_pct    = s;
        decoded_pct = d;
        margin_pct  = m;
    endtask

    // Random files of mixed kinds until the byte budget is spent
    task automatic run_random(input int budget, input bit no_gaps);
        int spent, len;
        spent = 0;
        while (spent < budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
            // last file is trimmed to the budget
            if (len > budget - spent) len = budget - spent;
            send_file(t_file_kind'($urandom_range(0, 4)), len,
                      NOISE_LEVELS[$urandom_range(0, 4)], no_gaps);
            spent += len;
        end
    endtask

    // Result side: random stalls, stall-free stretches, one long hold on request
    initial begin : result_sink
        int n;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (SINK_LONG_HOLD) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (sink_no_stall || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                n = pick_gap() + 1;
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_verdict got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.decision   = t_decision'(o_m_tdata[1:0]);
            got.byte_total = o_m_tdata[26:2];
            got.raw_good   = o_m_tdata[51:27];
            got.best_good  = o_m_tdata[76:52];
            got.length_ovf = o_m_tdata[77];
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no file pending: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                files_done++;
                decisions_seen[want.decision]++;
                if (got.decision !== want.decision) begin
                    $error("decision: expected %0d, got %0d", want.decision, got.decision);
                    fail_count++;
                end
                if (got.byte_total !== want.byte_total) begin
                    $error("byte_total: expected %0d, got %0d", want.byte_total,
                           got.byte_total);
                    fail_count++;
                end
                if (got.raw_good !== want.raw_good) begin
                    $error("raw_good_count: expected %0d, got %0d", want.raw_good,
                           got.raw_good);
                    fail_count++;
                end
                if (got.best_good !== want.best_good) begin
                    $error("best_good_count: expected %0d, got %0d", want.best_good,
                           got.best_good);
                    fail_count++;
                end
                if (got.length_ovf !== want.length_ovf) begin
                    $error("length_overflow: expected %0d, got %0d", want.length_ovf,
                           got.length_ovf);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_RAW_SKIP;
        i_cfg_data <= '0;
        skip_pct    = RST_RAW_SKIP;
        decoded_pct = RST_MIN_DECODED;
        margin_pct  = RST_MIN_MARGIN;
        cnt_total = '0;
        cnt_raw   = '0;
        cnt_cp037 = '0;
        cnt_cp500 = '0;
        cnt_ovf   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats against reset thresholds
        for (int k = 0; k < SCRIPT_LEN; k++)
            feed_byte(SCRIPT[k].data, SCRIPT[k].last, pick_gap(), SCRIPT[k].typed,
                      SCRIPT[k].want);
        wait_drained();

        // random phases, each under its own thresholds
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_PRESETS)
                set_thresholds(PRESET_SKIP[p], PRESET_DECODED[p], PRESET_MARGIN[p]);
            else
                set_thresholds(PCT_W'($urandom_range(0, 127)), PCT_W'($urandom_range(0, 127)),
                               PCT_W'($urandom_range(0, 127)));
            sink_no_stall = (p % 3 == 2);
            if (p == PRESSURE_PHASE) begin
                // back up one-byte files behind a held result port
                sink_hold_req = 1'b1;
                for (int k = 0; k < BURST_FILES; k++)
                    send_file(TXT_NOISE, 1, 100, 1'b1);
            end
            run_random(RANDOM_BYTES / N_PHASES, p % 3 == 1);
            wait_drained();
        end

        $display("covered %0d bytes in %0d files under %0d threshold settings",
                 bytes_sent, files_done, N_PHASES + 1);
        $display("verdicts keep/cp037/cp500: %0d/%0d/%0d; counter saturation not reached",
                 decisions_seen[DEC_KEEP], decisions_seen[DEC_CP037],
                 decisions_seen[DEC_CP500]);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
